// ----- hdl/nmr_pkg.sv -----
// Shared types and constants for the nonmonotone merit reference window.
package nmr_pkg;

  localparam int MERIT_W    = 32;                   // Q16.16 merit width
  localparam int CNT_W      = 5;                    // stored count / window length width
  localparam int SUM_W      = MERIT_W + CNT_W;      // exact sum of up to 31 merits
  localparam int STEP_W     = $clog2(SUM_W + 1);    // divider step counter
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  // mode register codes
  localparam logic [1:0] MODE_MAX  = 2'd0;
  localparam logic [1:0] MODE_MEAN = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

  // request function codes
  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_COMMIT = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [MERIT_W-1:0] current_merit;
    logic signed [MERIT_W-1:0] record_value;
    logic                      step_ok;
  } item_t;

  typedef struct packed {
    logic signed [MERIT_W-1:0] reference;
    logic                      mode_error;
    logic [CNT_W-1:0]          count_now;
  } result_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MERIT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/nmr_div.sv -----
// Serial restoring divider: signed window sum over stored count, truncating toward zero.
module nmr_div import nmr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy;
  logic                done;
  logic                neg;
  logic [STEP_W-1:0]   steps;
  logic [CNT_W-1:0]    rem;
  logic [SUM_W-1:0]    quo;
  logic [CNT_W:0]      shifted;
  logic [CNT_W+1:0]    trial;
  logic [SUM_W-1:0]    quo_signed;

  assign shifted = {rem, quo[SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (steps == STEP_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg   <= req.dividend[SUM_W-1];
      quo   <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
      rem   <= '0;
      steps <= STEP_W'(SUM_W);
    end else if (busy) begin
      // remainder stays below the divisor, so CNT_W bits hold it
      rem   <= trial[CNT_W+1] ? shifted[CNT_W-1:0] : trial[CNT_W-1:0];
      quo   <= {quo[SUM_W-2:0], ~trial[CNT_W+1]};
      steps <= steps - STEP_W'(1);
    end
  end

  assign quo_signed   = neg ? (~quo + SUM_W'(1)) : quo;
  assign rsp.done     = done;
  assign rsp.quotient = quo_signed[MERIT_W-1:0];

endmodule

// ----- hdl/nonmonotone_merit_reference.sv -----
// Top level: merit history window with max / mean reference queries and commits.
//
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+-----------------------------------
//  item     | item_valid, item_ready, item              | query or commit request
//  result   | result_valid, result_ready, result        | one result per request
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write (0 mode, 1 window)
//
// Sequencing: a commit, or a query in disabled/unsupported mode or with an empty
// window, goes straight to the output stage. A max query makes one history memory
// read per stored entry. A mean query then also runs the serial divider
// (one quotient bit per cycle).
// Reset: mode goes to disabled, window length and stored count to zero; history
// memory is not cleared, entries at or above the count are never read.
// Stalls: item_ready is high only while idle; a finished result waits in the
// output register while the next request is taken.
module nonmonotone_merit_reference import nmr_pkg::*; #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;  // stream stored entries out of the memory
  localparam logic [1:0] ST_DIV  = 2'd2;  // wait on the mean division
  localparam logic [1:0] ST_FIN  = 2'd3;  // hand the result to the output register

  logic [1:0]                state;
  logic [1:0]                mode;
  logic [CNT_W-1:0]          window_len;
  logic [CNT_W-1:0]          w_eff;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          head;       // oldest slot once the window has wrapped
  logic [CNT_W-1:0]          idx;        // next memory address to read
  logic                      acc_en;     // read data valid this cycle
  logic signed [MERIT_W-1:0] acc_max;
  logic signed [MERIT_W-1:0] acc_max_next;
  logic signed [SUM_W-1:0]   acc_sum;
  logic signed [SUM_W-1:0]   acc_sum_next;
  logic signed [MERIT_W-1:0] cur;
  logic signed [MERIT_W-1:0] res_ref;
  logic signed [MERIT_W-1:0] mean;
  logic                      div_start;

  logic signed [MERIT_W-1:0] mem [WINDOW_MAX];
  logic signed [MERIT_W-1:0] rd_data;
  logic                      rd_en;
  logic                      mem_we;
  logic [AW-1:0]             mem_wa;

  logic                      accept;
  logic                      cfg_write;
  logic                      is_commit;
  logic                      out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign w_eff = (int'(window_len) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) : window_len;

  assign item_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign is_commit  = (item.func == FUNC_COMMIT);

  // commit write: append below the window, else overwrite the oldest slot
  assign mem_we = accept && is_commit && item.step_ok && (w_eff != '0);
  assign mem_wa = (count < w_eff) ? AW'(count) : AW'(head);
  assign rd_en  = (state == ST_WALK) && (idx != count);

  // max and sum do not depend on entry order, so slots 0..count-1 are walked in place
  assign acc_max_next = (acc_en && (rd_data > acc_max)) ? rd_data : acc_max;
  assign acc_sum_next = acc_en ? (acc_sum + SUM_W'(rd_data)) : acc_sum;

  assign mean     = div_rsp.quotient;
  assign out_load = (state == ST_FIN) && (!result_valid || result_ready);

  assign div_req.start    = div_start;
  assign div_req.dividend = acc_sum;
  assign div_req.divisor  = count;

  nmr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= item.record_value;
    end
    if (rd_en) begin
      rd_data <= mem[AW'(idx)];
    end
  end

  // control and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= MODE_OFF;
      window_len <= '0;
      count      <= '0;
      head       <= '0;
      acc_en     <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          REG_MODE: begin
            mode <= cfg_data[1:0];
          end
          REG_WINDOW: begin
            window_len <= cfg_data;
            count      <= '0;
            head       <= '0;
          end
          default: begin
          end
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_commit) begin
              if (!item.step_ok) begin
                count <= '0;
                head  <= '0;
              end else if (count < w_eff) begin
                count <= count + CNT_W'(1);
              end else if (w_eff != '0) begin
                head <= (head + CNT_W'(1) == w_eff) ? '0 : head + CNT_W'(1);
              end
              state <= ST_FIN;
            end else if (((mode == MODE_MAX) || (mode == MODE_MEAN)) && (count != '0)) begin
              acc_en <= 1'b0;
              state  <= ST_WALK;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_WALK: begin
          acc_en <= rd_en;
          if (idx == count) begin
            if (mode == MODE_MEAN) begin
              div_start <= 1'b1;
              state     <= ST_DIV;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur     <= item.current_merit;
        acc_max <= item.current_merit;
        acc_sum <= '0;
        idx     <= '0;
        res_ref <= is_commit ? '0 : item.current_merit;
      end
      ST_WALK: begin
        acc_max <= acc_max_next;
        acc_sum <= acc_sum_next;
        if (rd_en) begin
          idx <= idx + CNT_W'(1);
        end
        if (idx == count) begin
          res_ref <= acc_max_next;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_ref <= (mean < cur) ? mean : cur;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.reference  <= res_ref;
      result.mode_error <= (mode == MODE_BAD);
      result.count_now  <= count;
    end
  end

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    count <= w_eff)
    else $error("stored count beyond effective window");

  a_head_zero_until_full: assert property (@(posedge clk) disable iff (rst)
    (count < w_eff) |-> (head == '0))
    else $error("ring head moved before window filled");

  a_walk_needs_entries: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> ((count != '0) && ((mode == MODE_MAX) || (mode == MODE_MEAN))))
    else $error("history walk without entries or in wrong mode");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside mean wait");

endmodule
